FILE: rtl/tcw_pkg.sv
package tcw_pkg;

  // Default grid geometry.
  localparam int unsigned ROWS_DEF = 24;
  localparam int unsigned COLS_DEF = 80;

  // Field widths fixed by the stream and register formats.
  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned ROW_W    = 5;
  localparam int unsigned COL_W    = 7;
  localparam int unsigned SCROLL_W = 5;
  localparam int unsigned TDATA_W  = 24;

  localparam logic [SCROLL_W-1:0] SCROLL_RESET = SCROLL_W'(10);

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = CHAR_W'(10);
  localparam logic [CHAR_W-1:0] SPACE_CODE   = CHAR_W'(32);

  // Item opcodes carried in tuser.
  localparam logic [OPCODE_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_READ  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;      // an item is accepted this cycle
    logic put;       // store the character and move the cursor
    logic read;      // read the addressed cell
    logic ptr_clr;   // restart the sweep pointer at cell 0
    logic copy_rd;   // read the source cell of a scroll copy
    logic copy_wr;   // write the copied cell and advance
    logic fill;      // write a space and advance
    logic zero;      // write a zero and advance
    logic load_out;  // load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic wrap;        // the put in flight pushes the cursor past the last row
    logic copy_empty;  // the scroll moves no rows
    logic copy_last;   // the pointer is on the last copied cell
    logic sweep_last;  // the pointer is on the last cell of the grid
    logic out_free;    // the result register can take a new result
  } sts_t;

endpackage

FILE: rtl/text_console_writer_core.sv
// Text console writer. The block keeps a ROWS x COLS grid of character
// cells in a single-port-write, single-port-read memory, plus a cursor.
// Each input transaction carries an opcode in tuser (put character, read
// cell, clear screen) and yields exactly one output transaction with the
// cell byte (zero unless it was an in-range read) and the cursor after the
// item. Items are handled one at a time. A put or read goes to a response
// state, which loads the result register once that register is free, and
// the block then returns to idle, ready to accept the next item. A clear
// sweeps the memory one cell per cycle before its response. A put that
// pushes the cursor past the last row scrolls the grid by S rows
// (scroll_lines, with 0 taken as 1 and values above ROWS taken as ROWS):
// the memory copy reads and then writes each moved cell, and the fill
// with spaces then writes one cell per cycle. After reset the block
// zeroes the memory in a clearing pass over all ROWS*COLS cells
// (1920 at the default size) before it accepts the first item; the
// scroll_lines register can be written over the APB port at any time the
// block is idle, including during that pass.
module text_console_writer_core
  import tcw_pkg::*;
#(
  parameter int unsigned ROWS = ROWS_DEF,
  parameter int unsigned COLS = COLS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Input stream.
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  // tdata: char_code[7:0], read_row[12:8], read_col[19:13], zero fill.
  input  logic [TDATA_W-1:0] s_axis_tdata_i,
  // tuser: opcode[1:0].
  input  logic [OPCODE_W-1:0] s_axis_tuser_i,
  // Output stream.
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  // tdata: cell_data[7:0], cursor_row_out[12:8], cursor_col_out[19:13], zeros.
  output logic [TDATA_W-1:0] m_axis_tdata_o,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [SCROLL_W-1:0] scroll_lines_q;
  logic                cfg_wr;

  // The only register, scroll_lines, sits at byte address 0.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? 32'(scroll_lines_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scroll_lines_q <= SCROLL_RESET;
    end else if (cfg_wr) begin
      scroll_lines_q <= pwdata[SCROLL_W-1:0];
    end
  end

  cmd_t cmd;
  sts_t sts;

  // The controller sequences each transaction through put, read, copy,
  // fill and clear steps; the datapath owns the grid memory and cursor.
  tcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .opcode_i   (s_axis_tuser_i),
    .sts_i      (sts),
    .in_ready_o (s_axis_tready_o),
    .cmd_o      (cmd)
  );

  logic [CHAR_W-1:0] cell_data;
  logic [ROW_W-1:0]  cursor_row;
  logic [COL_W-1:0]  cursor_col;

  tcw_dp #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .scroll_lines_i (scroll_lines_q),
    .char_code_i    (s_axis_tdata_i[7:0]),
    .read_row_i     (s_axis_tdata_i[12:8]),
    .read_col_i     (s_axis_tdata_i[19:13]),
    .out_ready_i    (m_axis_tready_i),
    .sts_o          (sts),
    .out_valid_o    (m_axis_tvalid_o),
    .cell_data_o    (cell_data),
    .cursor_row_o   (cursor_row),
    .cursor_col_o   (cursor_col)
  );

  assign m_axis_tdata_o = {4'b0000, cursor_col, cursor_row, cell_data};

endmodule

FILE: rtl/tcw_ctrl.sv
module tcw_ctrl
  import tcw_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [OPCODE_W-1:0] opcode_i,
  input  sts_t                sts_i,
  output logic                in_ready_o,
  output cmd_t                cmd_o
);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_FILL,
    ST_CLEAR,
    ST_RESP
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_ready_o && in_valid_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_INIT: begin
        cmd_o.zero = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_o.take    = 1'b1;
          cmd_o.ptr_clr = 1'b1;
          case (opcode_i)
            OP_PUT: begin
              cmd_o.put = 1'b1;
              if (!sts_i.wrap) begin
                state_d = ST_RESP;
              end else if (sts_i.copy_empty) begin
                state_d = ST_FILL;
              end else begin
                state_d = ST_COPY_RD;
              end
            end
            OP_READ: begin
              cmd_o.read = 1'b1;
              state_d    = ST_RESP;
            end
            OP_CLEAR: begin
              state_d = ST_CLEAR;
            end
            default: begin
              state_d = ST_RESP;
            end
          endcase
        end
      end
      ST_COPY_RD: begin
        cmd_o.copy_rd = 1'b1;
        state_d       = ST_COPY_WR;
      end
      ST_COPY_WR: begin
        cmd_o.copy_wr = 1'b1;
        state_d       = sts_i.copy_last ? ST_FILL : ST_COPY_RD;
      end
      ST_FILL: begin
        cmd_o.fill = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = ST_RESP;
        end
      end
      ST_CLEAR: begin
        cmd_o.zero = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/tcw_dp.sv
module tcw_dp
  import tcw_pkg::*;
#(
  parameter int unsigned ROWS = ROWS_DEF,
  parameter int unsigned COLS = COLS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  input  logic [SCROLL_W-1:0] scroll_lines_i,
  input  logic [CHAR_W-1:0]   char_code_i,
  input  logic [ROW_W-1:0]    read_row_i,
  input  logic [COL_W-1:0]    read_col_i,
  input  logic                out_ready_i,
  output sts_t                sts_o,
  output logic                out_valid_o,
  output logic [CHAR_W-1:0]   cell_data_o,
  output logic [ROW_W-1:0]    cursor_row_o,
  output logic [COL_W-1:0]    cursor_col_o
);

  localparam int unsigned CELLS = ROWS * COLS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned CW    = $clog2(COLS);
  localparam int unsigned SW    = $clog2(ROWS + 1);

  logic [CHAR_W-1:0] mem [CELLS];

  logic [RW-1:0]     row_q;
  logic [CW-1:0]     col_q;
  logic [AW-1:0]     ptr_q;
  logic              rd_sel_q;
  logic [CHAR_W-1:0] rdata_q;
  logic              out_valid_q;
  logic [CHAR_W-1:0] out_data_q;
  logic [ROW_W-1:0]  out_row_q;
  logic [COL_W-1:0]  out_col_q;

  // Effective scroll amount, kept within one row and the whole grid.
  logic [SW-1:0] scroll_amt;
  logic [AW-1:0] src_off;
  logic [AW-1:0] copy_len;
  logic [RW-1:0] scroll_row;

  always_comb begin
    if (scroll_lines_i == '0) begin
      scroll_amt = SW'(1);
    end else if (32'(scroll_lines_i) > ROWS) begin
      scroll_amt = SW'(ROWS);
    end else begin
      scroll_amt = SW'(scroll_lines_i);
    end
  end

  assign src_off    = AW'(32'(scroll_amt) * COLS);
  assign copy_len   = AW'((ROWS - 32'(scroll_amt)) * COLS);
  assign scroll_row = RW'(ROWS - 32'(scroll_amt));

  // Cursor advance for a put.
  logic          is_newline;
  logic          next_row;
  logic          wrap;
  logic [AW-1:0] cur_addr;

  assign is_newline = (char_code_i == NEWLINE_CODE);
  assign next_row   = is_newline || (32'(col_q) == COLS - 1);
  assign wrap       = next_row && (32'(row_q) == ROWS - 1);
  assign cur_addr   = AW'(32'(row_q) * COLS + 32'(col_q));

  // Cell read address.
  logic          rd_in_range;
  logic [AW-1:0] rd_addr;

  assign rd_in_range = (32'(read_row_i) < ROWS) && (32'(read_col_i) < COLS);
  assign rd_addr     = AW'(32'(read_row_i) * COLS + 32'(read_col_i));

  // Memory port selection.
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CHAR_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;

  always_comb begin
    mem_we    = cmd_i.copy_wr || cmd_i.fill || cmd_i.zero || (cmd_i.put && !is_newline);
    mem_waddr = cmd_i.put ? cur_addr : ptr_q;
    if (cmd_i.put) begin
      mem_wdata = char_code_i;
    end else if (cmd_i.copy_wr) begin
      mem_wdata = rdata_q;
    end else if (cmd_i.fill) begin
      mem_wdata = SPACE_CODE;
    end else begin
      mem_wdata = '0;
    end
    mem_re    = cmd_i.copy_rd || (cmd_i.read && rd_in_range);
    mem_raddr = cmd_i.read ? rd_addr : AW'(ptr_q + src_off);
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= '0;
      col_q       <= '0;
      ptr_q       <= '0;
      rd_sel_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.put) begin
        if (wrap) begin
          row_q <= scroll_row;
          col_q <= '0;
        end else if (next_row) begin
          row_q <= RW'(row_q + 1'b1);
          col_q <= '0;
        end else begin
          col_q <= CW'(col_q + 1'b1);
        end
      end
      if (cmd_i.ptr_clr) begin
        ptr_q <= '0;
      end else if (cmd_i.copy_wr || cmd_i.fill || cmd_i.zero) begin
        ptr_q <= AW'(ptr_q + 1'b1);
      end
      if (cmd_i.take) begin
        rd_sel_q <= cmd_i.read && rd_in_range;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_data_q <= rd_sel_q ? rdata_q : '0;
      out_row_q  <= ROW_W'(row_q);
      out_col_q  <= COL_W'(col_q);
    end
  end

  assign sts_o.wrap       = wrap;
  assign sts_o.copy_empty = (32'(scroll_amt) == ROWS);
  assign sts_o.copy_last  = (ptr_q == AW'(copy_len - 1'b1));
  assign sts_o.sweep_last = (32'(ptr_q) == CELLS - 1);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign cell_data_o  = out_data_q;
  assign cursor_row_o = out_row_q;
  assign cursor_col_o = out_col_q;

endmodule
